FILE: sv/oale_pkg.sv
// shared types and constants for the ordered array list engine
// no dependencies
package oale_pkg;

    // action codes of an input item
    localparam logic [2:0] ACT_APPEND    = 3'd0;
    localparam logic [2:0] ACT_INSERT    = 3'd1;
    localparam logic [2:0] ACT_OVERWRITE = 3'd2;
    localparam logic [2:0] ACT_READ      = 3'd3;
    localparam logic [2:0] ACT_DELETE    = 3'd4;
    localparam logic [2:0] ACT_DROP      = 3'd5;

    // status codes of a result item
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // field widths
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 7;

    // accepted list operation, broadcast to every cell
    typedef struct packed {
        logic app;
        logic ins;
        logic ovw;
        logic del;
    } t_cell_op;

endpackage

FILE: sv/oale_cell.sv
// one list cell: holds the entry at a fixed position and shifts with its neighbors
// depends on oale_pkg
module oale_cell
    import oale_pkg::*;
#(
    parameter int unsigned POS = 0,
    parameter int unsigned XW  = 8
) (
    input  logic                     i_clk,
    input  t_cell_op                 i_op,
    input  logic [XW-1:0]            i_index,
    input  logic [XW-1:0]            i_count,
    input  logic signed [WORD_W-1:0] i_value,
    input  logic signed [WORD_W-1:0] i_left,
    input  logic signed [WORD_W-1:0] i_right,
    output logic signed [WORD_W-1:0] o_data,
    output logic signed [WORD_W-1:0] o_tap
);

    localparam logic [XW-1:0] P = XW'(POS);

    logic signed [WORD_W-1:0] r_data;
    logic signed [WORD_W-1:0] n_data;

    // next entry value from the broadcast operation
    always_comb begin
        n_data = r_data;
        if (i_op.app && (P == i_count)) begin
            n_data = i_value;
        end else if (i_op.ins) begin
            if (P == i_index) begin
                n_data = i_value;
            end else if ((P > i_index) && (P <= i_count)) begin
                n_data = i_left;
            end
        end else if (i_op.ovw && (P == i_index)) begin
            n_data = i_value;
        end else if (i_op.del && (P >= i_index) && ((P + XW'(1)) < i_count)) begin
            n_data = i_right;
        end
    end

    // entry register
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // read tap, zero unless this cell is addressed
    assign o_tap  = (P == i_index) ? r_data : '0;

endmodule

FILE: sv/ordered_array_list_engine_unit.sv
// ordered list of up to DEPTH signed words held in a chain of shifting cells
// result strobe comes in the cycle after start is taken; throughput one item per cycle
// busy stays low: every cell shifts in the same cycle, so no item waits on another
// reset (synchronous, active low) clears the count and the strobe; cell contents
// are undefined until written. the receiver cannot stall
module ordered_array_list_engine_unit
    import oale_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                i_action,
    input  logic [IDX_W-1:0]          i_index,
    input  logic signed [WORD_W-1:0]  i_value,
    output logic                      o_strobe,
    output logic signed [WORD_W-1:0]  o_read_value,
    output logic [1:0]                o_status,
    output logic [COUNT_W-1:0]        o_count
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned XW = CW + IDX_W;

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     r_strobe;
    logic signed [WORD_W-1:0] r_read_value;
    logic signed [WORD_W-1:0] n_read_value;
    logic [1:0]               r_status;
    logic [1:0]               n_status;

    logic                     w_go;
    logic [XW-1:0]            w_idx;
    logic [XW-1:0]            w_cnt;
    logic [XW-1:0]            w_cnt_out;
    t_cell_op                 w_op;
    logic                     w_rd_ok;
    logic signed [WORD_W-1:0] w_rd;
    logic signed [WORD_W-1:0] w_data [DEPTH];
    logic signed [WORD_W-1:0] w_tap  [DEPTH];

    assign busy  = 1'b0;
    assign w_go  = start && !busy;
    assign w_idx = XW'(i_index);
    assign w_cnt = XW'(r_count);

    // decode action, check bounds, pick status and new count
    always_comb begin
        w_op     = '0;
        w_rd_ok  = 1'b0;
        n_status = ST_DONE;
        n_count  = r_count;
        unique case (i_action)
            ACT_APPEND: begin
                if (w_cnt == XW'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    w_op.app = w_go;
                    n_count  = r_count + CW'(1);
                end
            end
            ACT_INSERT: begin
                if (w_idx > w_cnt) begin
                    n_status = ST_RANGE;
                end else if (w_cnt == XW'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    w_op.ins = w_go;
                    n_count  = r_count + CW'(1);
                end
            end
            ACT_OVERWRITE: begin
                if (w_idx >= w_cnt) begin
                    n_status = ST_RANGE;
                end else begin
                    w_op.ovw = w_go;
                end
            end
            ACT_READ: begin
                if (w_idx >= w_cnt) begin
                    n_status = ST_RANGE;
                end else begin
                    w_rd_ok = 1'b1;
                end
            end
            ACT_DELETE: begin
                if (w_idx >= w_cnt) begin
                    n_status = ST_RANGE;
                end else begin
                    w_op.del = w_go;
                    n_count  = r_count - CW'(1);
                end
            end
            ACT_DROP: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // chain of cells
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic signed [WORD_W-1:0] w_left;
        logic signed [WORD_W-1:0] w_right;
        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[k+1];
        end
        oale_cell #(
            .POS (k),
            .XW  (XW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_index (w_idx),
            .i_count (w_cnt),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[k]),
            .o_tap   (w_tap[k])
        );
    end

    // collect the addressed cell's word
    always_comb begin
        w_rd = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd = w_rd | w_tap[k];
        end
        n_read_value = w_rd_ok ? w_rd : '0;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_go;
            if (w_go) begin
                r_count <= n_count;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
        end
    end

    assign w_cnt_out    = XW'(r_count);
    assign o_strobe     = r_strobe;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_count      = w_cnt_out[COUNT_W-1:0];

endmodule

FILE: verif/list_result_checker.sv
// result checker for the ordered array list engine: mirrors the list, predicts each result
// depends on oale_pkg for action and status codes and field widths
`timescale 1ns / 1ps
module list_result_checker
    import oale_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic [2:0]                i_action,
    input  logic [IDX_W-1:0]          i_index,
    input  logic signed [WORD_W-1:0]  i_value,
    input  logic                      i_strobe,
    input  logic signed [WORD_W-1:0]  i_read_value,
    input  logic [1:0]                i_status,
    input  logic [COUNT_W-1:0]        i_count,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked
);

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       count;
    } t_list_result;

    // mirror of the list contents and its length
    logic signed [WORD_W-1:0] mirror_words [DEPTH];
    int unsigned              mirror_count = 0;
    t_list_result             expected_results [$];
    int                       fail_count = 0;
    int                       checked = 0;

    // apply one list operation to the mirror and form its result
    task automatic apply_list_op(input logic [2:0] act, input logic [IDX_W-1:0] idx,
                                 input logic signed [WORD_W-1:0] val,
                                 output t_list_result res);
        int unsigned pos;
        res.read_value = '0;
        res.status     = ST_DONE;
        case (act)
            ACT_APPEND: begin
                if (mirror_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    mirror_words[mirror_count] = val;
                    mirror_count++;
                end
            end
            ACT_INSERT: begin
                // range check takes priority over the full check
                if (idx > mirror_count) begin
                    res.status = ST_RANGE;
                end else if (mirror_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (pos = mirror_count; pos > idx; pos--)
                        mirror_words[pos] = mirror_words[pos-1];
                    mirror_words[idx] = val;
                    mirror_count++;
                end
            end
            ACT_OVERWRITE: begin
                if (idx >= mirror_count) res.status = ST_RANGE;
                else mirror_words[idx] = val;
            end
            ACT_READ: begin
                if (idx >= mirror_count) res.status = ST_RANGE;
                else res.read_value = mirror_words[idx];
            end
            ACT_DELETE: begin
                if (idx >= mirror_count) begin
                    res.status = ST_RANGE;
                end else begin
                    for (pos = idx; pos + 1 < mirror_count; pos++)
                        mirror_words[pos] = mirror_words[pos+1];
                    mirror_count--;
                end
            end
            ACT_DROP: begin
                if (mirror_count == 0) res.status = ST_EMPTY;
                else mirror_count--;
            end
            default: begin
                // spare action codes leave the list alone
            end
        endcase
        res.count = mirror_count[COUNT_W-1:0];
    endtask

    // compare results against the oldest prediction, then predict the new item
    always @(posedge i_clk) begin : watch
        t_list_result want;
        t_list_result made;
        if (!i_rst_n) begin
            expected_results.delete();
            mirror_count = 0;
        end else begin
            if (i_strobe) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item waiting: read_value %0d status %0d count %0d",
                           i_read_value, i_status, i_count);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (i_read_value !== want.read_value) begin
                        $error("read_value: expected %0d, actual %0d",
                               want.read_value, i_read_value);
                        fail_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        fail_count++;
                    end
                    if (i_count !== want.count) begin
                        $error("count: expected %0d, actual %0d", want.count, i_count);
                        fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                apply_list_op(i_action, i_index, i_value, made);
                expected_results.push_back(made);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
        o_checked    <= checked;
    end

endmodule

FILE: verif/tb.sv
// testbench top for the ordered array list engine: clock, reset, stimulus and verdict
// depends on oale_pkg, ordered_array_list_engine_unit and list_result_checker
`timescale 1ns / 1ps
module tb
    import oale_pkg::*;
();

    localparam int unsigned DEPTH       = 64;
    localparam logic [2:0]  ACT_SPARE_LO = 3'd6;
    localparam logic [2:0]  ACT_SPARE_HI = 3'd7;
    localparam int          RANDOM_ITEMS = 750;
    localparam int          BLOCK_ITEMS  = 40;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          MODE_FILL    = 0;
    localparam int          MODE_DRAIN   = 1;
    localparam int          MODE_MIX     = 2;

    logic                     i_clk    = 1'b0;
    logic                     i_rst_n  = 1'b0;
    logic                     start    = 1'b0;
    logic [2:0]               i_action = ACT_READ;
    logic [IDX_W-1:0]         i_index  = '0;
    logic signed [WORD_W-1:0] i_value  = '0;
    logic                     busy;
    logic                     o_strobe;
    logic signed [WORD_W-1:0] o_read_value;
    logic [1:0]               o_status;
    logic [COUNT_W-1:0]       o_count;

    int               fail_count;
    int               pending;
    int               checked;
    int               cycle_count = 0;
    int               items_sent  = 0;
    int               idle_pct    = 0;
    logic [COUNT_W-1:0] seen_count = '0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ordered_array_list_engine_unit #(.DEPTH(DEPTH)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_index      (i_index),
        .i_value      (i_value),
        .o_strobe     (o_strobe),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count)
    );

    list_result_checker #(.DEPTH(DEPTH)) list_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_action     (i_action),
        .i_index      (i_index),
        .i_value      (i_value),
        .i_strobe     (o_strobe),
        .i_read_value (o_read_value),
        .i_status     (o_status),
        .i_count      (o_count),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // last reported length, used to aim indexes at live entries
    always @(posedge i_clk) begin
        if (o_strobe) seen_count <= o_count;
    end

    // issue one item, wait for it to be taken, then maybe idle
    task automatic send_item(input logic [2:0] act, input logic [IDX_W-1:0] idx,
                             input logic signed [WORD_W-1:0] val);
        start    <= 1'b1;
        i_action <= act;
        i_index  <= idx;
        i_value  <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // action mix depends on whether the list should grow, shrink or wander
    function automatic logic [2:0] pick_action(input int mode);
        int roll;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                if (roll < 42) return ACT_APPEND;
                if (roll < 77) return ACT_INSERT;
                if (roll < 83) return ACT_OVERWRITE;
                if (roll < 92) return ACT_READ;
                if (roll < 96) return ACT_DELETE;
                if (roll < 98) return ACT_DROP;
            end
            MODE_DRAIN: begin
                if (roll < 38) return ACT_DELETE;
                if (roll < 66) return ACT_DROP;
                if (roll < 82) return ACT_READ;
                if (roll < 90) return ACT_OVERWRITE;
                if (roll < 94) return ACT_APPEND;
                if (roll < 98) return ACT_INSERT;
            end
            default: begin
                if (roll < 17) return ACT_APPEND;
                if (roll < 34) return ACT_INSERT;
                if (roll < 51) return ACT_OVERWRITE;
                if (roll < 68) return ACT_READ;
                if (roll < 83) return ACT_DELETE;
                if (roll < 98) return ACT_DROP;
            end
        endcase
        return (roll[0]) ? ACT_SPARE_HI : ACT_SPARE_LO;
    endfunction

    // mostly a live position, sometimes anywhere in the index range
    function automatic logic [IDX_W-1:0] pick_index();
        int lim;
        lim = (seen_count > 63) ? 63 : int'(seen_count);
        if ($urandom_range(0, 3) == 0) return IDX_W'($urandom_range(0, 63));
        return IDX_W'($urandom_range(0, lim));
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // stimulus and verdict
    initial begin : stimulus
        int phase_pct [4];
        int counted;
        int block_left;
        int mode;
        logic [2:0] act;
        phase_pct = '{0, 59, 34, 0};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list cases first
        send_item(ACT_READ,      6'd0,  32'sd5);
        send_item(ACT_DROP,      6'd0,  32'sd0);
        send_item(ACT_DELETE,    6'd0,  32'sd0);
        send_item(ACT_OVERWRITE, 6'd0,  32'sd7);
        send_item(ACT_INSERT,    6'd1,  32'sd9);
        // build a short list with the value extremes
        send_item(ACT_INSERT,    6'd0,  32'sh7FFF_FFFF);
        send_item(ACT_APPEND,    6'd0,  32'sh8000_0000);
        send_item(ACT_APPEND,    6'd63, 32'sd0);
        send_item(ACT_APPEND,    6'd0,  -32'sd1);
        // insert at the count behaves as append, past it is out of range
        send_item(ACT_INSERT,    6'd4,  32'sh1234_5678);
        send_item(ACT_INSERT,    6'd7,  32'sd1);
        send_item(ACT_INSERT,    6'd1,  32'shAAAA_AAAA);
        send_item(ACT_OVERWRITE, 6'd2,  32'sh5555_5555);
        send_item(ACT_READ,      6'd0,  32'sd0);
        send_item(ACT_READ,      6'd1,  32'sd0);
        send_item(ACT_READ,      6'd2,  32'sd0);
        send_item(ACT_READ,      6'd63, 32'sd0);
        // spare action codes
        send_item(ACT_SPARE_LO,  6'd1,  32'sd3);
        send_item(ACT_SPARE_HI,  6'd63, -32'sd1);
        // removal at the front, at the tail and out of range
        send_item(ACT_DELETE,    6'd0,  32'sd0);
        send_item(ACT_DELETE,    6'd4,  32'sd0);
        send_item(ACT_DELETE,    6'd5,  32'sd0);
        send_item(ACT_DROP,      6'd0,  32'sd0);
        send_item(ACT_READ,      6'd2,  32'sd0);

        // random: four idle mixes, each in blocks that favor fill, drain or a mix
        for (int p = 0; p < 4; p++) begin
            idle_pct   = phase_pct[p];
            counted    = 0;
            block_left = 0;
            mode       = MODE_MIX;
            while (counted < RANDOM_ITEMS / 4) begin
                if (block_left == 0) begin
                    mode       = $urandom_range(MODE_FILL, MODE_MIX);
                    block_left = BLOCK_ITEMS;
                end
                act = pick_action(mode);
                send_item(act, pick_index(), pick_value());
                if (act <= ACT_DROP) begin
                    counted++;
                    block_left--;
                end
            end
        end
        start <= 1'b0;

        // drain outstanding results
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d items: directed edge cases, then fill, drain and mixed blocks", items_sent);
        $display("under four idle mixes; %0d results compared", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
